// File: hw/rtl/max_weight_nonadjacent_select_core_defines.svh
// ----------------------------------------------------------------------------
// Max weight non-adjacent select: assertion macros
// Shared property shapes for the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MAX_WEIGHT_NONADJACENT_SELECT_CORE_DEFINES_SVH
`define MAX_WEIGHT_NONADJACENT_SELECT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MWNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mwns_pkg.sv
// ----------------------------------------------------------------------------
// Max weight non-adjacent select: package
// Field widths, request and result types, sequencer states.
// ----------------------------------------------------------------------------
package mwns_pkg;

    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 6;
    localparam int TOTAL_W  = 21;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } request_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               chosen;
        logic [TOTAL_W-1:0] best_total;
        logic               truncated;
        logic               end_of_run;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TB_RD,
        ST_TB_CMP,
        ST_TB_TAKE,
        ST_TB_HI,
        ST_EMIT
    } state_t;

endpackage

// File: hw/rtl/max_weight_nonadjacent_select_core.sv
// ----------------------------------------------------------------------------
// Max weight non-adjacent select core
// Best non-adjacent subset of a weight sequence, with traceback and emission.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request (weight, last) with start high; a request is taken at a
//   rising edge where start is high and busy is low. While loading, busy
//   stays low and one weight is taken per cycle. Requests beyond MAX_ITEMS
//   are dropped and mark the run as truncated.
//   A request with last set closes the run: busy rises, the core walks the
//   prefix-best RAM back from the end (a skipped position passes the read and
//   compare states, a taken pair above position one also the take and
//   upper-value states), then reads the chosen-mark RAM once per position and
//   emits one result per cycle in ascending position order.
//   Each result sits on result for exactly one cycle, marked by
//   result_strobe; the receiver cannot stall, so the core never waits.
//   busy falls in the cycle of the final strobe, and a new run may start
//   at once.
//   Reset clears the sequencer, item count and truncation flag; the RAMs need
//   no clearing, as position zero of the best table is forced to zero on
//   read and traceback writes every mark of the run before it is emitted.
// ----------------------------------------------------------------------------
`include "max_weight_nonadjacent_select_core_defines.svh"

module max_weight_nonadjacent_select_core #(
    parameter int MAX_ITEMS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mwns_pkg::request_t request,
    output logic               result_strobe,
    output mwns_pkg::result_t  result
);

    // Count and index width: must hold MAX_ITEMS itself.
    localparam int CW = $clog2(MAX_ITEMS + 1);
    // Best RAM has MAX_ITEMS + 1 entries, mark RAM MAX_ITEMS entries.
    localparam int BA = CW;
    localparam int MA = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    // Prefix bests never exceed MAX_ITEMS full-scale weights.
    localparam int BW = mwns_pkg::WEIGHT_W + $clog2(MAX_ITEMS + 1);

    mwns_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [BW-1:0] prev1_reg, prev1_next;
    logic [BW-1:0] prev2_reg, prev2_next;
    logic [BW-1:0] total_reg, total_next;
    logic [BW-1:0] hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          lo_zero_reg, lo_zero_next;

    // Result stage
    logic                             strobe_reg, strobe_next;
    logic [mwns_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [mwns_pkg::TOTAL_W-1:0]     out_total_reg, out_total_next;
    logic                             trunc_reg, trunc_next;
    logic                             eor_reg, eor_next;

    // RAM ports
    logic          best_we, best_re;
    logic [BA-1:0] best_waddr, best_raddr;
    logic [BW-1:0] best_wdata, best_rdata;
    logic          mark_we, mark_re;
    logic [MA-1:0] mark_waddr, mark_raddr;
    logic          mark_wdata, mark_rdata;

    logic          accept;
    logic          has_room;
    logic [BW-1:0] weight_ext;
    logic [BW-1:0] take_sum;
    logic [BW-1:0] new_best;
    logic [BW-1:0] cmp_lo;
    logic          cmp_equal;
    logic          emit_last;

    mwns_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_ITEMS + 1)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .re    (best_re),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    mwns_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ITEMS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign busy       = (state_reg != mwns_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign has_room   = (count_reg < CW'(MAX_ITEMS));
    assign weight_ext = BW'(request.weight);
    assign take_sum   = prev2_reg + weight_ext;
    // Tie takes the item; either way the value is the same.
    assign new_best   = (prev1_reg > take_sum) ? prev1_reg : take_sum;
    // Entry zero of the prefix table reads as zero.
    assign cmp_lo     = lo_zero_reg ? '0 : best_rdata;
    assign cmp_equal  = (hi_reg == cmp_lo);
    assign emit_last  = ((idx_reg + CW'(1)) == count_reg);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwns_pkg::ST_IDLE:
            begin
                if (accept && request.last)
                begin
                    state_next = mwns_pkg::ST_TB_RD;
                end
            end
            mwns_pkg::ST_TB_RD:
            begin
                state_next = (idx_reg == '0) ? mwns_pkg::ST_EMIT : mwns_pkg::ST_TB_CMP;
            end
            mwns_pkg::ST_TB_CMP:
            begin
                if (cmp_equal || !(idx_reg > CW'(1)))
                begin
                    state_next = mwns_pkg::ST_TB_RD;
                end
                else
                begin
                    state_next = mwns_pkg::ST_TB_TAKE;
                end
            end
            mwns_pkg::ST_TB_TAKE:
            begin
                state_next = mwns_pkg::ST_TB_HI;
            end
            mwns_pkg::ST_TB_HI:
            begin
                state_next = mwns_pkg::ST_TB_RD;
            end
            mwns_pkg::ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = mwns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mwns_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        prev1_next     = prev1_reg;
        prev2_next     = prev2_reg;
        total_next     = total_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        lo_zero_next   = lo_zero_reg;
        strobe_next    = 1'b0;
        pos_next       = pos_reg;
        out_total_next = out_total_reg;
        trunc_next     = trunc_reg;
        eor_next       = eor_reg;

        best_we    = 1'b0;
        best_waddr = BA'(count_reg + CW'(1));
        best_wdata = new_best;
        best_re    = 1'b0;
        best_raddr = BA'(idx_reg - CW'(1));
        mark_we    = 1'b0;
        mark_waddr = MA'(idx_reg - CW'(1));
        mark_wdata = 1'b0;
        mark_re    = 1'b0;
        mark_raddr = MA'(idx_reg);

        unique case (state_reg)
            mwns_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        // Store the new prefix best and slide the window.
                        best_we    = 1'b1;
                        count_next = count_reg + CW'(1);
                        prev2_next = prev1_reg;
                        prev1_next = new_best;
                    end
                    else
                    begin
                        // Drop the weight, flag the run.
                        ovf_next = 1'b1;
                    end
                    if (request.last)
                    begin
                        total_next = has_room ? new_best : prev1_reg;
                        hi_next    = has_room ? new_best : prev1_reg;
                        idx_next   = has_room ? (count_reg + CW'(1)) : count_reg;
                    end
                end
            end
            mwns_pkg::ST_TB_RD:
            begin
                // Fetch best[i-1]; idx zero hands over to emission at position one.
                if (idx_reg != '0)
                begin
                    best_re      = 1'b1;
                    lo_zero_next = (idx_reg == CW'(1));
                end
            end
            mwns_pkg::ST_TB_CMP:
            begin
                mark_we = 1'b1;
                if (cmp_equal)
                begin
                    // Skip: best[i-1] becomes the new upper value.
                    mark_wdata = 1'b0;
                    hi_next    = cmp_lo;
                    idx_next   = idx_reg - CW'(1);
                end
                else
                begin
                    mark_wdata = 1'b1;
                    idx_next   = (idx_reg > CW'(1)) ? (idx_reg - CW'(2)) : '0;
                end
            end
            mwns_pkg::ST_TB_TAKE:
            begin
                // Clear the neighbour below a taken position, fetch the prefix best below that neighbour.
                mark_we      = 1'b1;
                mark_waddr   = MA'(idx_reg);
                mark_wdata   = 1'b0;
                best_re      = 1'b1;
                best_raddr   = BA'(idx_reg);
                lo_zero_next = (idx_reg == '0);
            end
            mwns_pkg::ST_TB_HI:
            begin
                hi_next = cmp_lo;
            end
            mwns_pkg::ST_EMIT:
            begin
                mark_re        = 1'b1;
                strobe_next    = 1'b1;
                pos_next       = mwns_pkg::POS_W'(idx_reg + CW'(1));
                out_total_next = mwns_pkg::TOTAL_W'(total_reg);
                trunc_next     = ovf_reg;
                eor_next       = emit_last;
                idx_next       = idx_reg + CW'(1);
                if (emit_last)
                begin
                    // Close the run and start empty.
                    count_next = '0;
                    ovf_next   = 1'b0;
                    prev1_next = '0;
                    prev2_next = '0;
                    idx_next   = '0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mwns_pkg::ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            prev1_reg  <= '0;
            prev2_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            prev1_reg  <= prev1_next;
            prev2_reg  <= prev2_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg     <= total_next;
        hi_reg        <= hi_next;
        lo_zero_reg   <= lo_zero_next;
        pos_reg       <= pos_next;
        out_total_reg <= out_total_next;
        trunc_reg     <= trunc_next;
        eor_reg       <= eor_next;
    end

    assign result_strobe     = strobe_reg;
    assign result.position   = pos_reg;
    assign result.chosen     = mark_rdata;
    assign result.best_total = out_total_reg;
    assign result.truncated  = trunc_reg;
    assign result.end_of_run = eor_reg;

    `MWNS_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CW'(MAX_ITEMS), "item count beyond capacity")
    `MWNS_ASSERT_NEXT(a_emit_strobes, state_reg == mwns_pkg::ST_EMIT, result_strobe, "emission cycle without a result")
    `MWNS_ASSERT_NEXT(a_last_marks_end, (state_reg == mwns_pkg::ST_EMIT) && emit_last, result.end_of_run && !busy, "final result not marked or core still busy")
    `MWNS_ASSERT_NOW(a_cmp_idx_nonzero, state_reg == mwns_pkg::ST_TB_CMP, idx_reg != '0, "traceback compare below position one")

endmodule

// File: hw/rtl/mwns_ram.sv
// ----------------------------------------------------------------------------
// Max weight non-adjacent select: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mwns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
